// ===== design/multi_camera_frame_timestamp_aligner_defines.svh =====
// Assertion macros shared by the timestamp aligner modules.
`ifndef MULTI_CAMERA_FRAME_TIMESTAMP_ALIGNER_DEFINES_SVH
`define MULTI_CAMERA_FRAME_TIMESTAMP_ALIGNER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MCFTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MCFTA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mcfta_pkg.sv =====
// Types and constants shared by the timestamp aligner modules.
package mcfta_pkg;

  localparam int CAM_W      = 3;
  localparam int TIME_W     = 64;
  localparam int TAG_W      = 9;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int INDEX_SPAN = 8;
  localparam int TAG_CMP_W  = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_HELD   = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_SET    = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic         load;       // capture the arriving request
    logic         commit;     // write the request into its camera slot
    logic         echo;       // emit a result that echoes the request
    result_kind_t echo_kind;
    logic         idx_clear;  // return the slot walker to camera 0
    logic         scan_step;  // fold one slot into the max search
    logic         emit_step;  // drop or emit one slot
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic complete;
    logic idx_last;
  } dp_status_t;

endpackage

// ===== design/mcfta_ctrl.sv =====
// Sequencer for the timestamp aligner: check, max scan and emit passes.
`include "multi_camera_frame_timestamp_aligner_defines.svh"

module mcfta_ctrl import mcfta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t sts,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.reject) begin
          cmd.echo      = 1'b1;
          cmd.echo_kind = KIND_REJECT;
          state_next    = ST_IDLE;
        end else if (!sts.complete) begin
          cmd.commit    = 1'b1;
          cmd.echo      = 1'b1;
          cmd.echo_kind = KIND_HELD;
          state_next    = ST_IDLE;
        end else begin
          cmd.commit    = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  `MCFTA_ASSERT(a_start_sets_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `MCFTA_ASSERT(a_emit_end_idle, (state == ST_EMIT && sts.idx_last) |=> !busy, "emit pass did not release busy")
  `MCFTA_ASSERT_ALWAYS(a_busy_tracks_state, rst || busy == (state != ST_IDLE), "busy out of step with state")

endmodule

// ===== design/mcfta_dp.sv =====
// Datapath of the timestamp aligner: slots, max search and result register.
`include "multi_camera_frame_timestamp_aligner_defines.svh"

module mcfta_dp import mcfta_pkg::*; #(
  parameter int SLOTS              = 8,
  parameter int BUFFERS_PER_CAMERA = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CAM_W-1:0]   camera_index,
  input  logic [TIME_W-1:0]  frame_time,
  input  logic [TAG_W-1:0]   buffer_tag,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  input  dp_cmd_t            cmd,
  output dp_status_t         sts,
  output logic               result_valid,
  output logic [KIND_W-1:0]  result_kind,
  output logic [CAM_W-1:0]   out_camera,
  output logic [TAG_W-1:0]   out_tag,
  output logic [TIME_W-1:0]  out_time,
  output logic               last_of_run
);

  localparam int SLOT_W = $clog2(SLOTS);

  logic [COUNT_W-1:0] cfg_count;
  logic [COUNT_W-1:0] n_act;
  logic [CAM_W-1:0]   cam_q;
  logic [TIME_W-1:0]  time_q;
  logic [TAG_W-1:0]   tag_q;

  logic [SLOTS-1:0]   slot_full, slot_full_next;
  logic [TIME_W-1:0]  slot_time [SLOTS];
  logic [TAG_W-1:0]   slot_tag  [SLOTS];

  logic [SLOTS-1:0]   act_mask, cam_dec, idx_dec, eq_mask, drop_mask, drop_above;
  logic [SLOT_W-1:0]  idx;
  logic [TIME_W-1:0]  max_t, rd_time;
  logic [TAG_W-1:0]   rd_tag;
  logic               all_eq, fire, emit_last;

  // Effective camera count: zero acts as one, saturate at the slot count.
  always_comb begin
    if (cfg_count == '0) begin
      n_act = COUNT_W'(1);
    end else if (cfg_count > COUNT_W'(SLOTS)) begin
      n_act = COUNT_W'(SLOTS);
    end else begin
      n_act = cfg_count;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      act_mask[i] = COUNT_W'(i) < n_act;
      cam_dec[i]  = cam_q == CAM_W'(i);
    end
  end

  assign idx_dec = SLOTS'(1) << idx;
  assign rd_time = slot_time[idx];
  assign rd_tag  = slot_tag[idx];

  assign sts.reject   = ({1'b0, cam_q} >= n_act)
                     || (TAG_CMP_W'(tag_q) >= TAG_CMP_W'(BUFFERS_PER_CAMERA))
                     || (|(slot_full & cam_dec));
  assign sts.complete = &(slot_full | cam_dec | ~act_mask);
  assign sts.idx_last = COUNT_W'(idx) == (n_act - COUNT_W'(1));

  assign all_eq     = &(eq_mask | ~act_mask);
  assign drop_mask  = act_mask & ~eq_mask;
  assign drop_above = (drop_mask >> idx) >> 1;
  assign fire       = all_eq || (|(drop_mask & idx_dec));
  assign emit_last  = all_eq ? sts.idx_last : (drop_above == '0);

  always_comb begin
    slot_full_next = slot_full;
    if (cmd.commit) begin
      slot_full_next = slot_full_next | cam_dec;
    end
    if (cmd.emit_step && fire) begin
      slot_full_next = slot_full_next & ~idx_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count    <= COUNT_W'(1);
      slot_full    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_count <= cfg_data;
      end
      slot_full    <= slot_full_next;
      result_valid <= cmd.echo || (cmd.emit_step && fire);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cam_q  <= camera_index;
      time_q <= frame_time;
      tag_q  <= buffer_tag;
    end
    if (cmd.commit) begin
      slot_time[cam_q[SLOT_W-1:0]] <= time_q;
      slot_tag[cam_q[SLOT_W-1:0]]  <= tag_q;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.scan_step || cmd.emit_step) begin
      idx <= idx + SLOT_W'(1);
    end
    // Track the running max and which slots sit at it.
    if (cmd.scan_step) begin
      if (idx == '0 || rd_time > max_t) begin
        max_t   <= rd_time;
        eq_mask <= idx_dec;
      end else if (rd_time == max_t) begin
        eq_mask <= eq_mask | idx_dec;
      end
    end
    if (cmd.echo) begin
      result_kind <= cmd.echo_kind;
      out_camera  <= cam_q;
      out_tag     <= tag_q;
      out_time    <= time_q;
      last_of_run <= 1'b1;
    end else if (cmd.emit_step && fire) begin
      result_kind <= all_eq ? KIND_SET : KIND_DROP;
      out_camera  <= CAM_W'(idx);
      out_tag     <= rd_tag;
      out_time    <= rd_time;
      last_of_run <= emit_last;
    end
  end

  `MCFTA_ASSERT(a_set_clears, (result_valid && result_kind == KIND_SET && last_of_run) |-> ((slot_full & act_mask) == '0), "frameset left active slots full")
  `MCFTA_ASSERT(a_echo_last, (result_valid && (result_kind == KIND_HELD || result_kind == KIND_REJECT)) |-> last_of_run, "held or rejected result not marked last")
  `MCFTA_ASSERT(a_commit_free, cmd.commit |-> !(|(slot_full & cam_dec)), "frame written over a full slot")

endmodule

// ===== design/multi_camera_frame_timestamp_aligner.sv =====
// Top level of the multi-camera frame timestamp aligner.
// A held or rejected request is decided in the check state, which registers its result.
// A request that completes the set runs the check, one slot walk for the max search
// and one for emits; busy holds off the next request until the sequencer is idle again.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (rst, synchronous): all slots empty, camera count 1, no result pending.

module multi_camera_frame_timestamp_aligner import mcfta_pkg::*; #(
  parameter int MAX_CAMERAS        = 8,
  parameter int BUFFERS_PER_CAMERA = 512
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [CAM_W-1:0]   camera_index,
  input  logic [TIME_W-1:0]  frame_time,
  input  logic [TAG_W-1:0]   buffer_tag,
  // camera count register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] camera_count,
  // result channel
  output logic               result_valid,
  output logic [KIND_W-1:0]  result_kind,
  output logic [CAM_W-1:0]   out_camera,
  output logic [TAG_W-1:0]   out_tag,
  output logic [TIME_W-1:0]  out_time,
  output logic               last_of_run
);

  // camera_index reaches only eight cameras, so no more slots are ever used.
  localparam int SLOTS = (MAX_CAMERAS < INDEX_SPAN) ? MAX_CAMERAS : INDEX_SPAN;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Take register writes only between requests.
  assign cfg_ready = !busy;

  // The sequencer: check the request, then walk slots for max and for emits.
  mcfta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Slots, max search and the one-cycle result register.
  mcfta_dp #(
    .SLOTS              (SLOTS),
    .BUFFERS_PER_CAMERA (BUFFERS_PER_CAMERA)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .camera_index (camera_index),
    .frame_time   (frame_time),
    .buffer_tag   (buffer_tag),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (camera_count),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .out_camera   (out_camera),
    .out_tag      (out_tag),
    .out_time     (out_time),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== tb/frame_align_check.sv =====
// Predictor and result comparator for the multi-camera frame timestamp aligner.
`timescale 1ns / 100ps

module frame_align_check import mcfta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [CAM_W-1:0]   camera_index,
  input  logic [TIME_W-1:0]  frame_time,
  input  logic [TAG_W-1:0]   buffer_tag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] camera_count,
  input  logic               result_valid,
  input  logic [KIND_W-1:0]  result_kind,
  input  logic [CAM_W-1:0]   out_camera,
  input  logic [TAG_W-1:0]   out_tag,
  input  logic [TIME_W-1:0]  out_time,
  input  logic               last_of_run,
  output int unsigned        mismatch_count,
  output int unsigned        awaited_count
);

  localparam int NUM_SLOTS  = 8;
  localparam int TAG_LIMIT  = 512;
  localparam int REPORT_MAX = 10;

  typedef struct {
    result_kind_t      kind;
    logic [CAM_W-1:0]  cam;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    logic              closes_run;
  } frame_result_t;

  frame_result_t      awaited_results[$];
  logic [COUNT_W-1:0] count_reg;
  logic               slot_held  [NUM_SLOTS];
  logic [TIME_W-1:0]  slot_stamp [NUM_SLOTS];
  logic [TAG_W-1:0]   slot_tag   [NUM_SLOTS];

  // Zero acts as one camera; anything past the slot count saturates.
  function automatic int unsigned live_cameras(input logic [COUNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > NUM_SLOTS) return NUM_SLOTS;
    return raw;
  endfunction

  // Fold one accepted request into the slot state and queue the results it causes.
  task automatic align_frame(input logic [CAM_W-1:0] cam, input logic [TIME_W-1:0] stamp,
                             input logic [TAG_W-1:0] tag);
    int unsigned       n;
    int                i;
    logic [TIME_W-1:0] newest;
    bit                all_same;
    frame_result_t     item;
    frame_result_t     run[$];
    n = live_cameras(count_reg);
    if (cam >= n || int'(tag) >= TAG_LIMIT || slot_held[cam]) begin
      item = '{KIND_REJECT, cam, tag, stamp, 1'b1};
      awaited_results.push_back(item);
      return;
    end
    slot_held[cam]  = 1'b1;
    slot_stamp[cam] = stamp;
    slot_tag[cam]   = tag;
    for (i = 0; i < n; i++) begin
      if (!slot_held[i]) begin
        item = '{KIND_HELD, cam, tag, stamp, 1'b1};
        awaited_results.push_back(item);
        return;
      end
    end
    newest = '0;
    for (i = 0; i < n; i++)
      if (slot_stamp[i] > newest) newest = slot_stamp[i];
    all_same = 1'b1;
    for (i = 0; i < n; i++)
      if (slot_stamp[i] != newest) all_same = 1'b0;
    // Emit the whole set when aligned, otherwise drop the stale ones.
    for (i = 0; i < n; i++) begin
      if (all_same || slot_stamp[i] != newest) begin
        item.kind       = all_same ? KIND_SET : KIND_DROP;
        item.cam        = CAM_W'(i);
        item.tag        = slot_tag[i];
        item.stamp      = slot_stamp[i];
        item.closes_run = 1'b0;
        run.push_back(item);
        slot_held[i] = 1'b0;
      end
    end
    run[run.size() - 1].closes_run = 1'b1;
    foreach (run[j]) awaited_results.push_back(run[j]);
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      awaited_results.delete();
      count_reg      = 1;
      mismatch_count = 0;
      for (int s = 0; s < NUM_SLOTS; s++) slot_held[s] = 1'b0;
    end else begin
      // Results first: they always belong to requests accepted earlier.
      if (result_valid !== 1'b0) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("[%0t] unexpected result: kind %0d cam %0d tag %0d time %h last %b",
                     $time, result_kind, out_camera, out_tag, out_time, last_of_run);
        end else begin
          want = awaited_results.pop_front();
          if (result_kind !== want.kind || out_camera !== want.cam || out_tag !== want.tag ||
              out_time !== want.stamp || last_of_run !== want.closes_run) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("[%0t] result mismatch: expected kind %0d cam %0d tag %0d time %h last %b",
                       $time, want.kind, want.cam, want.tag, want.stamp, want.closes_run);
              $display("[%0t]                  actual   kind %0d cam %0d tag %0d time %h last %b",
                       $time, result_kind, out_camera, out_tag, out_time, last_of_run);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) count_reg = camera_count;
      if (start && !busy) align_frame(camera_index, frame_time, buffer_tag);
    end
    awaited_count = awaited_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, clock, reset and verdict for the multi-camera frame timestamp aligner.
`timescale 1ns / 100ps

module tb_top;
  import mcfta_pkg::*;

  localparam int          CAMERA_SLOTS  = 8;
  // Longest request walks 8 slots twice, once to scan and once to emit; leave headroom.
  localparam int          SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 35;
  localparam int          NUM_PHASES    = 12;
  localparam logic [TIME_W-1:0] FRAME_PERIOD = 64'd33_333_333;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CAM_W-1:0]   camera_index;
  logic [TIME_W-1:0]  frame_time;
  logic [TAG_W-1:0]   buffer_tag;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] camera_count;
  logic               result_valid;
  logic [KIND_W-1:0]  result_kind;
  logic [CAM_W-1:0]   out_camera;
  logic [TAG_W-1:0]   out_tag;
  logic [TIME_W-1:0]  out_time;
  logic               last_of_run;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned cycle_count = 0;
  bit          gaps_on;
  // Running video clock for rounds that model steady capture.
  logic [TIME_W-1:0] timeline = '0;

  // Camera counts for the random phases: extremes, out-of-range values and
  // zero among them, so every register bit toggles.
  logic [COUNT_W-1:0] phase_counts [NUM_PHASES] =
    '{4'd2, 4'd8, 4'd4, 4'd1, 4'd13, 4'd6, 4'd3, 4'd0, 4'd7, 4'd15, 4'd5, 4'd8};

  multi_camera_frame_timestamp_aligner dut (.*);

  frame_align_check align_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_camera_frame_timestamp_aligner regression: fail");
      $finish;
    end
  end

  // Offer one frame request and hold it until the block takes it. Start stays
  // high on return so back-to-back requests need no extra assignment.
  task automatic send_frame(input logic [CAM_W-1:0] cam, input logic [TIME_W-1:0] stamp,
                            input logic [TAG_W-1:0] tag);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      // Drop start for a random gap.
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    start        = 1'b1;
    camera_index = cam;
    frame_time   = stamp;
    buffer_tag   = tag;
    // Busy only moves at a rising edge, so the value seen here holds for the next one.
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drain all outstanding results, then write the camera count while idle.
  task automatic set_camera_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid    = 1'b1;
    camera_count = value;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One well-formed round: every live camera sends one frame, in shuffled
  // order, mostly sharing one timestamp so whole sets align; a few frames
  // run early or late to force drops.
  task automatic play_round(input int unsigned live, output int unsigned sent);
    int unsigned       order [CAMERA_SLOTS];
    int unsigned       pick;
    int unsigned       swap;
    int                i;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] stamp;
    for (i = 0; i < CAMERA_SLOTS; i++) order[i] = i;
    for (i = live - 1; i > 0; i--) begin
      pick     = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[pick];
      order[pick] = swap;
    end
    case ($urandom_range(0, 3))
      0: base = {$urandom, $urandom};
      1: base = '1 - TIME_W'($urandom_range(0, 3));
      2: base = TIME_W'($urandom_range(0, 15));
      default: begin
        timeline = timeline + FRAME_PERIOD;
        base     = timeline;
      end
    endcase
    for (i = 0; i < live; i++) begin
      stamp = base;
      case ($urandom_range(0, 9))
        0: stamp = base - TIME_W'($urandom_range(1, 500));
        1: stamp = base + TIME_W'($urandom_range(1, 500));
        default: ;
      endcase
      send_frame(CAM_W'(order[i]), stamp, TAG_W'($urandom_range(0, 511)));
    end
    sent = live;
  endtask

  initial begin
    int unsigned        live;
    int unsigned        sent;
    int unsigned        got;
    int                 p;
    int                 c;
    logic [COUNT_W-1:0] raw;
    rst          = 1'b1;
    start        = 1'b0;
    camera_index = '0;
    frame_time   = '0;
    buffer_tag   = '0;
    cfg_valid    = 1'b0;
    camera_count = '0;
    gaps_on      = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single camera after reset: each accepted frame is a one-member set.
    send_frame(3'd0, 64'd0, 9'd0);
    send_frame(3'd0, '1, 9'd511);
    // Index beyond the live count: reject.
    send_frame(3'd7, 64'd5, 9'd3);

    // Zero count behaves as one camera.
    set_camera_count(4'd0);
    send_frame(3'd0, 64'h5555_5555_5555_5555, 9'h155);
    send_frame(3'd1, 64'haaaa_aaaa_aaaa_aaaa, 9'h0aa);

    // Three cameras: hold, reject an occupied slot, then complete an equal set.
    set_camera_count(4'd3);
    send_frame(3'd0, 64'd100, 9'd1);
    send_frame(3'd0, 64'd200, 9'd2);
    send_frame(3'd2, 64'd100, 9'd3);
    send_frame(3'd1, 64'd100, 9'd4);
    // Unequal completion: drop the stale camera, keep the newest two.
    send_frame(3'd1, 64'd9, 9'd5);
    send_frame(3'd0, 64'd5, 9'd6);
    send_frame(3'd2, 64'd9, 9'd7);
    // Refill the dropped slot to realign the set.
    send_frame(3'd0, 64'd9, 9'd8);
    // Leave one slot held across a count change.
    send_frame(3'd2, '1, 9'h0aa);

    // Count above the slot count saturates to eight; the held slot joins in.
    set_camera_count(4'd15);
    send_frame(3'd0, '1, 9'd10);
    send_frame(3'd1, '1, 9'd11);
    send_frame(3'd2, '1, 9'd12);
    send_frame(3'd3, '1, 9'd13);
    send_frame(3'd4, '1, 9'd14);
    send_frame(3'd5, '1, 9'd15);
    send_frame(3'd6, '1, 9'd16);
    send_frame(3'd7, '1, 9'd17);
    send_frame(3'd5, 64'h8000_0000_0000_0000, 9'h100);

    // Shrink while camera 5 is held: only cameras 0 and 1 take part now.
    set_camera_count(4'd2);
    send_frame(3'd1, 64'd7, 9'd11);
    send_frame(3'd0, 64'd3, 9'd12);

    // Random phases: mostly full rounds with random content, some noise
    // requests on any camera with any timestamp. No idling in the last two.
    for (p = 0; p < NUM_PHASES; p++) begin
      raw = phase_counts[p];
      set_camera_count(raw);
      gaps_on = (p < NUM_PHASES - 2);
      live    = (raw == 0) ? 1 : ((raw > CAMERA_SLOTS) ? CAMERA_SLOTS : raw);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          c = $urandom_range(0, CAMERA_SLOTS - 1);
          send_frame(CAM_W'(c), {$urandom, $urandom}, TAG_W'($urandom_range(0, 511)));
          sent++;
        end else begin
          play_round(live, got);
          sent += got;
        end
      end
    end

    // Drop start, wait for every expected result and let the pipe go quiet.
    @(negedge clk);
    start = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("multi_camera_frame_timestamp_aligner regression: pass");
    end else begin
      $display("multi_camera_frame_timestamp_aligner regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mcfta_pkg.sv
design/mcfta_ctrl.sv
design/mcfta_dp.sv
design/multi_camera_frame_timestamp_aligner.sv
tb/frame_align_check.sv
tb/tb_top.sv
